// ===== rtl/core/cts_pkg.sv =====
// Package for the cooperative task scheduler: field widths, codes, the
// broadcast and token structs shared by the top level and the task cells.
// No dependencies.
`timescale 1ns / 1ps

package cts_pkg;

  // Field widths fixed by the item formats
  localparam int ACT_W      = 3;
  localparam int SEM_W      = 3;
  localparam int CNT_W      = 8;
  localparam int TICK_W     = 16;
  localparam int DELAY_W    = 15;
  localparam int TID_W      = 4;
  localparam int TCNT_W     = 4;
  localparam int WOKEN_W    = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  // A 4-bit slot count reaches 15 slots at most; a 3-bit id reaches 8 semaphores
  localparam int MAX_CELLS = 15;
  localparam int MAX_SEMS  = 8;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELAY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TASK_COUNT = 2'd1;

  // Register reset values
  localparam logic [DELAY_W-1:0] MAX_DELAY_RST  = 15'd16384;
  localparam logic [TCNT_W-1:0]  TASK_COUNT_RST = 4'd8;

  // Counter ceiling and tick epoch constants
  localparam logic [CNT_W-1:0]   CNT_MAX   = 8'hFF;
  localparam logic [TICK_W-1:0]  EPOCH_BIT = 16'h8000;
  localparam logic [DELAY_W-1:0] LOW_MASK  = 15'h7FFF;

  typedef enum logic [ACT_W-1:0] {
    ACT_SEM_INIT = 3'd0,
    ACT_DELAY    = 3'd1,
    ACT_WAIT     = 3'd2,
    ACT_SIGNAL   = 3'd3,
    ACT_DISPATCH = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    TS_RUNNING = 2'd0,
    TS_IDLE    = 2'd1,
    TS_DELAYED = 2'd2,
    TS_WAITING = 2'd3
  } task_state_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_PASS = 2'd1,
    S_DONE = 2'd2
  } seq_state_t;

  // Event context broadcast to every cell while a token walks the chain
  typedef struct packed {
    action_t              action;
    logic [SEM_W-1:0]     sem;
    logic                 delay_nz;
    logic [TICK_W-1:0]    wake;
    logic [TICK_W-1:0]    now;
    logic                 cur_valid;
    logic [TID_W-1:0]     cur_idx;
    logic                 park;
    logic [TID_W-1:0]     cursor;
    logic [TCNT_W-1:0]    task_count;
    logic [DELAY_W-1:0]   max_delay;
    logic                 scan;
  } evt_t;

  // Token handed from cell to cell, one hop per cycle
  typedef struct packed {
    logic                 valid;
    logic                 found;
    logic [TID_W-1:0]     tid;
    logic [WOKEN_W-1:0]   woken;
    logic                 any_idle;
  } tok_t;

  // Wake tick test with the epoch-bit wrap rule
  function automatic logic has_expired(input logic [TICK_W-1:0]  wake_at,
                                       input logic [TICK_W-1:0]  tick,
                                       input logic [DELAY_W-1:0] max_delay);
    logic [DELAY_W-1:0] e;
    logic [DELAY_W-1:0] t;
    logic [TICK_W-1:0]  wrap_gap;
    logic               res;
    e        = wake_at[DELAY_W-1:0];
    t        = tick[DELAY_W-1:0];
    wrap_gap = {1'b0, LOW_MASK} - {1'b0, t} + {1'b0, e};
    if (((wake_at ^ tick) & EPOCH_BIT) != '0) begin
      res = !((e < t) && (wrap_gap <= {1'b0, max_delay}));
    end else begin
      res = !(wake_at > tick);
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/cts_intf.sv =====
// Channel interfaces of the task scheduler: input events, results and
// configuration writes. Depends on cts_pkg.
`timescale 1ns / 1ps

interface cts_in_if;
  import cts_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [cts_pkg::ACT_W-1:0]   action;
  logic [cts_pkg::SEM_W-1:0]   sem_id;
  logic [cts_pkg::CNT_W-1:0]   init_value;
  logic [cts_pkg::DELAY_W-1:0] delay_ticks;
  logic [cts_pkg::TICK_W-1:0]  now_tick;
  modport source (output valid, action, sem_id, init_value, delay_ticks, now_tick,
                  input ready);
  modport sink   (input valid, action, sem_id, init_value, delay_ticks, now_tick,
                  output ready);
endinterface

interface cts_out_if;
  import cts_pkg::*;
  logic                        valid;
  logic                        ready;
  logic [cts_pkg::TID_W-1:0]   task_id;
  logic                        dispatched;
  logic                        granted;
  logic                        may_sleep;
  logic [cts_pkg::WOKEN_W-1:0] woken_count;
  modport source (output valid, task_id, dispatched, granted, may_sleep, woken_count,
                  input ready);
  modport sink   (input valid, task_id, dispatched, granted, may_sleep, woken_count,
                  output ready);
endinterface

interface cts_cfg_if;
  import cts_pkg::*;
  logic                           valid;
  logic                           ready;
  logic [cts_pkg::CFG_IDX_W-1:0]  index;
  logic [cts_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/cooperative_task_scheduler_top.sv =====
// Top level of the cooperative round-robin task scheduler: sequencer,
// semaphore counters, configuration and the chain of task cells.
// Depends on cts_pkg, cts_intf and cts_cell.
`timescale 1ns / 1ps

// Channel  Modport  Contents
// in_if    sink     action, sem_id, init_value, delay_ticks, now_tick
// out_if   source   task_id, dispatched, granted, may_sleep, woken_count
// cfg_if   sink     index, data (always ready)
//
// One event at a time. N = min(MAX_TASKS, 15) cells; a token walks them one
// cell per cycle. Sem init needs no pass; delay, wait, signal, or a dispatch
// that finds a task walks the chain once; a dispatch that falls through to
// the expiry scan walks the chain twice. Synchronous active-low reset; no
// clearing pass. A result waiting on out_if holds the next event in its
// final step while the chain stays idle.

module cooperative_task_scheduler_top #(
  parameter int MAX_TASKS      = 8,
  parameter int NUM_SEMAPHORES = 8
) (
  input logic clk,
  input logic rst_n,
  cts_in_if.sink    in_if,
  cts_out_if.source out_if,
  cts_cfg_if.sink   cfg_if
);
  import cts_pkg::*;

  localparam int TASK_CELLS = (MAX_TASKS < MAX_CELLS) ? MAX_TASKS : MAX_CELLS;
  localparam int SEM_SLOTS  = (NUM_SEMAPHORES < MAX_SEMS) ? NUM_SEMAPHORES : MAX_SEMS;
  localparam int SEM_IDX_W  = (SEM_SLOTS > 1) ? $clog2(SEM_SLOTS) : 1;
  localparam int SEM_MOD_W  = 7;

  seq_state_t         state_r, state_nxt;
  logic               launch_r, launch_nxt;
  logic               in_ready;
  logic               out_load;
  logic               in_fire;
  logic               cfg_fire;
  logic               pass_end;
  logic               first_fail;
  logic               needs_pass;

  logic [TID_W-1:0]   current_r;
  logic [TID_W-1:0]   cursor_r;
  logic [CNT_W-1:0]   sem_cnt_r [SEM_SLOTS];
  logic [DELAY_W-1:0] mdt_r;
  logic [TCNT_W-1:0]  tcount_r;

  evt_t               evt_r, evt_nxt;
  logic [TID_W-1:0]   res_tid_r;
  logic               res_disp_r;
  logic               res_grant_r;
  logic               res_sleep_r;
  logic [WOKEN_W-1:0] res_woken_r;

  logic               out_valid_r;
  logic [TID_W-1:0]   out_tid_r;
  logic               out_disp_r;
  logic               out_grant_r;
  logic               out_sleep_r;
  logic [WOKEN_W-1:0] out_woken_r;

  action_t            act_in;
  logic [SEM_MOD_W-1:0] sem_v;
  logic [SEM_W-1:0]   sem_sel;
  logic [CNT_W-1:0]   cnt_sel;
  logic               cur_valid;
  logic               park;

  tok_t               chain [TASK_CELLS+1];
  tok_t               tok_last;

  assign in_fire  = in_if.valid && in_ready;
  assign cfg_fire = cfg_if.valid && cfg_if.ready;
  assign act_in   = action_t'(in_if.action);

  // Semaphore number folded into the counters in use
  always_comb begin
    sem_v = SEM_MOD_W'(in_if.sem_id);
    for (int k = 0; k < 7; k++) begin
      if (sem_v >= SEM_MOD_W'(NUM_SEMAPHORES)) begin
        sem_v = sem_v - SEM_MOD_W'(NUM_SEMAPHORES);
      end
    end
    sem_sel = sem_v[SEM_W-1:0];
  end

  assign cnt_sel   = sem_cnt_r[sem_sel[SEM_IDX_W-1:0]];
  assign cur_valid = current_r != '0;
  assign park      = (act_in == ACT_WAIT) && (cnt_sel == '0) && cur_valid;

  // Event context captured on accept
  always_comb begin
    evt_nxt.action     = act_in;
    evt_nxt.sem        = sem_sel;
    evt_nxt.delay_nz   = in_if.delay_ticks != '0;
    evt_nxt.wake       = in_if.now_tick + {1'b0, in_if.delay_ticks};
    evt_nxt.now        = in_if.now_tick;
    evt_nxt.cur_valid  = cur_valid;
    evt_nxt.cur_idx    = current_r - 1'b1;
    evt_nxt.park       = park;
    evt_nxt.cursor     = cursor_r;
    evt_nxt.task_count = tcount_r;
    evt_nxt.max_delay  = mdt_r;
    evt_nxt.scan       = 1'b0;
  end

  // Cell chain
  assign chain[0] = '{valid: launch_r, found: 1'b0, tid: '0, woken: '0, any_idle: 1'b0};

  for (genvar g = 0; g < TASK_CELLS; g++) begin : g_cell
    cts_cell #(.IDX(g)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .evt     (evt_r),
      .tok_in  (chain[g]),
      .tok_out (chain[g+1])
    );
  end

  assign tok_last   = chain[TASK_CELLS];
  assign pass_end   = (state_r == S_PASS) && tok_last.valid;
  assign first_fail = pass_end && (evt_r.action == ACT_DISPATCH) && !evt_r.scan &&
                      !tok_last.found;
  assign needs_pass = act_in inside {ACT_DELAY, ACT_WAIT, ACT_SIGNAL, ACT_DISPATCH};

  // Sequencer next state
  always_comb begin
    state_nxt  = state_r;
    launch_nxt = 1'b0;
    in_ready   = 1'b0;
    out_load   = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_if.valid) begin
          if (needs_pass) begin
            state_nxt  = S_PASS;
            launch_nxt = 1'b1;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_PASS: begin
        if (first_fail) begin
          launch_nxt = 1'b1;
        end else if (pass_end) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_if.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control state: config, current task, cursor, semaphores, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      launch_r    <= 1'b0;
      out_valid_r <= 1'b0;
      current_r   <= '0;
      cursor_r    <= '0;
      mdt_r       <= MAX_DELAY_RST;
      tcount_r    <= TASK_COUNT_RST;
      for (int s = 0; s < SEM_SLOTS; s++) begin
        sem_cnt_r[s] <= '0;
      end
    end else begin
      launch_r <= launch_nxt;

      if (cfg_fire) begin
        if (cfg_if.index == CFG_MAX_DELAY) begin
          mdt_r <= cfg_if.data;
        end else if (cfg_if.index == CFG_TASK_COUNT) begin
          tcount_r <= cfg_if.data[TCNT_W-1:0];
        end
      end

      if (in_fire) begin
        if (cur_valid && (act_in == ACT_DELAY || act_in == ACT_DISPATCH || park)) begin
          current_r <= '0;
        end
        case (act_in)
          ACT_SEM_INIT: sem_cnt_r[sem_sel[SEM_IDX_W-1:0]] <= in_if.init_value;
          ACT_WAIT: begin
            if (cnt_sel != '0) begin
              sem_cnt_r[sem_sel[SEM_IDX_W-1:0]] <= cnt_sel - 1'b1;
            end
          end
          ACT_SIGNAL: begin
            if (cnt_sel != CNT_MAX) begin
              sem_cnt_r[sem_sel[SEM_IDX_W-1:0]] <= cnt_sel + 1'b1;
            end
          end
          default: begin
          end
        endcase
      end

      // end of a dispatch pass
      if (pass_end && evt_r.action == ACT_DISPATCH) begin
        if (!evt_r.scan && tok_last.found) begin
          current_r <= tok_last.tid;
          cursor_r  <= tok_last.tid;
        end else if (evt_r.scan) begin
          cursor_r <= '0;
        end
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Event and result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      evt_r       <= evt_nxt;
      res_tid_r   <= (act_in == ACT_DISPATCH) ? '0 : current_r;
      res_disp_r  <= 1'b0;
      res_grant_r <= (act_in == ACT_WAIT) && (cnt_sel != '0);
      res_sleep_r <= 1'b0;
      res_woken_r <= '0;
    end
    if (first_fail) begin
      evt_r.scan <= 1'b1;
    end
    if (pass_end) begin
      if (evt_r.action == ACT_SIGNAL) begin
        res_woken_r <= tok_last.woken;
      end else if (evt_r.action == ACT_DISPATCH) begin
        if (!evt_r.scan && tok_last.found) begin
          res_tid_r  <= tok_last.tid;
          res_disp_r <= 1'b1;
        end else if (evt_r.scan) begin
          res_woken_r <= tok_last.woken;
          res_sleep_r <= !tok_last.any_idle;
        end
      end
    end
    if (out_load) begin
      out_tid_r   <= res_tid_r;
      out_disp_r  <= res_disp_r;
      out_grant_r <= res_grant_r;
      out_sleep_r <= res_sleep_r;
      out_woken_r <= res_woken_r;
    end
  end

  // Ports
  assign in_if.ready        = in_ready;
  assign cfg_if.ready       = 1'b1;
  assign out_if.valid       = out_valid_r;
  assign out_if.task_id     = out_tid_r;
  assign out_if.dispatched  = out_disp_r;
  assign out_if.granted     = out_grant_r;
  assign out_if.may_sleep   = out_sleep_r;
  assign out_if.woken_count = out_woken_r;

  // Checks
  a_token_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
    tok_last.valid |-> state_r == S_PASS)
    else $error("token left the chain outside a pass");

  a_ready_no_launch: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.ready |-> !launch_r)
    else $error("input ready while a token is being launched");

  a_disp_has_task: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.dispatched) |-> out_if.task_id != '0)
    else $error("dispatch result without a task");

  a_sleep_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.may_sleep) |-> (!out_if.dispatched && out_if.woken_count == '0))
    else $error("may_sleep together with a dispatch or a wakeup");

endmodule

// ===== rtl/core/cts_cell.sv =====
// One task slot of the scheduler chain: status, wake tick and semaphore of
// its task, plus the token stage that hands the event on. Depends on cts_pkg.
`timescale 1ns / 1ps

module cts_cell #(
  parameter int IDX = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  cts_pkg::evt_t evt,
  input  cts_pkg::tok_t tok_in,
  output cts_pkg::tok_t tok_out
);
  import cts_pkg::*;

  localparam logic [TID_W-1:0] MY_IDX = TID_W'(IDX);
  localparam logic [TID_W-1:0] MY_TID = TID_W'(IDX + 1);

  task_state_t         status_r, status_nxt;
  logic [TICK_W-1:0]   wake_r, wake_nxt;
  logic [SEM_W-1:0]    blk_r, blk_nxt;
  tok_t                tok_r, tok_nxt;

  logic        in_use;
  logic        is_cur;
  task_state_t eff;

  assign in_use = MY_IDX < evt.task_count;
  assign is_cur = evt.cur_valid && (evt.cur_idx == MY_IDX);

  // Slot update for the event carried by the token
  always_comb begin
    status_nxt = status_r;
    wake_nxt   = wake_r;
    blk_nxt    = blk_r;
    tok_nxt    = tok_in;
    eff        = is_cur ? TS_IDLE : status_r;
    if (tok_in.valid) begin
      case (evt.action)
        ACT_DELAY: begin
          if (is_cur) begin
            if (evt.delay_nz) begin
              status_nxt = TS_DELAYED;
              wake_nxt   = evt.wake;
            end else begin
              status_nxt = TS_IDLE;
            end
          end
        end
        ACT_WAIT: begin
          if (is_cur && evt.park) begin
            status_nxt = TS_WAITING;
            blk_nxt    = evt.sem;
          end
        end
        ACT_SIGNAL: begin
          if (in_use && status_r == TS_WAITING && blk_r == evt.sem) begin
            status_nxt    = TS_IDLE;
            tok_nxt.woken = tok_in.woken + 1'b1;
          end
        end
        ACT_DISPATCH: begin
          if (!evt.scan) begin
            // search pass: the current task is yielded on the way
            status_nxt = eff;
            if (!tok_in.found && in_use && MY_IDX >= evt.cursor && eff == TS_IDLE) begin
              status_nxt    = TS_RUNNING;
              tok_nxt.found = 1'b1;
              tok_nxt.tid   = MY_TID;
            end
          end else if (in_use) begin
            // expiry scan
            if (status_r == TS_DELAYED) begin
              if (has_expired(wake_r, evt.now, evt.max_delay)) begin
                status_nxt       = TS_IDLE;
                tok_nxt.woken    = tok_in.woken + 1'b1;
                tok_nxt.any_idle = 1'b1;
              end
            end else if (status_r == TS_IDLE) begin
              tok_nxt.any_idle = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Status and token valid are reset; stored payload is written before it is read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r    <= TS_IDLE;
      tok_r.valid <= 1'b0;
    end else begin
      status_r    <= status_nxt;
      tok_r.valid <= tok_nxt.valid;
    end
    wake_r         <= wake_nxt;
    blk_r          <= blk_nxt;
    tok_r.found    <= tok_nxt.found;
    tok_r.tid      <= tok_nxt.tid;
    tok_r.woken    <= tok_nxt.woken;
    tok_r.any_idle <= tok_nxt.any_idle;
  end

  assign tok_out = tok_r;

endmodule

// ===== sim/cooperative_task_scheduler_top_tb.sv =====
// Self-checking testbench for cooperative_task_scheduler_top: directed and random
// scheduling events, randomly stalled channels, results checked in order.
// Depends on cts_pkg, cts_intf and the scheduler RTL.
`timescale 1ns / 1ps

module cooperative_task_scheduler_top_tb;
  import cts_pkg::*;

  localparam int TB_TASKS = 8;
  localparam int TB_SEMS  = 8;
  // Longest event is a dispatch that falls into the expiry scan
  localparam int SETTLE_CYCLES = 2 * TB_TASKS + 8;

  // Action codes the block treats as no-ops
  localparam logic [ACT_W-1:0] ACT_RSVD5 = 3'd5;
  localparam logic [ACT_W-1:0] ACT_RSVD6 = 3'd6;
  localparam logic [ACT_W-1:0] ACT_RSVD7 = 3'd7;

  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic [SEM_W-1:0]   sem_id;
    logic [CNT_W-1:0]   init_value;
    logic [DELAY_W-1:0] delay_ticks;
    logic [TICK_W-1:0]  now_tick;
    logic               drain_first;  // hold off until every result is back
  } sched_evt_t;

  typedef struct packed {
    logic [TID_W-1:0]   task_id;
    logic               dispatched;
    logic               granted;
    logic               may_sleep;
    logic [WOKEN_W-1:0] woken_count;
  } sched_out_t;

  logic clk = 1'b0;
  logic rst_n;

  cts_in_if  in_if ();
  cts_out_if out_if ();
  cts_cfg_if cfg_if ();

  cooperative_task_scheduler_top #(
    .MAX_TASKS      (TB_TASKS),
    .NUM_SEMAPHORES (TB_SEMS)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  // Scheduler mirror: registers and state
  logic [DELAY_W-1:0] model_max_delay = MAX_DELAY_RST;
  logic [TCNT_W-1:0]  model_slots     = TASK_COUNT_RST;
  task_state_t        slot_state [TB_TASKS];
  logic [TICK_W-1:0]  slot_wake  [TB_TASKS];
  logic [SEM_W-1:0]   slot_sem   [TB_TASKS];
  logic [CNT_W-1:0]   sem_count  [TB_SEMS];
  int                 running_id = 0;
  int                 cursor     = 0;

  // Event stream and awaited results
  sched_evt_t event_q[$];
  sched_out_t outcome_q[$];
  sched_evt_t cur_evt;
  int         events_total = 0;
  int         events_taken = 0;
  int         mismatch_cnt = 0;
  logic       in_took      = 1'b0;
  logic       send_now;
  int         send_gap     = 0;
  int         stall_left   = 0;
  int         calm_left    = 0;
  logic [TICK_W-1:0] tick_gen = '0;
  sched_out_t got;
  sched_out_t exp_res;

  int phase_len   [7] = '{150, 220, 250, 80, 200, 250, 280};
  int phase_delay [7] = '{0, 32767, 16384, -1, -1, -1, 100};
  int phase_slots [7] = '{1, 15, 8, 0, 3, -1, 8};

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Wake test: when the epoch bits differ, a short wrap distance is still future
  function automatic bit tick_passed(input logic [TICK_W-1:0] wake_at,
                                     input logic [TICK_W-1:0] now_t);
    int e;
    int t;
    if (wake_at[TICK_W-1] != now_t[TICK_W-1]) begin
      e = int'(wake_at[DELAY_W-1:0]);
      t = int'(now_t[DELAY_W-1:0]);
      return !(e < t && (int'(LOW_MASK) - t + e) <= int'(model_max_delay));
    end
    return !(wake_at > now_t);
  endfunction

  // Apply one event to the mirror and return the result it produces
  function automatic sched_out_t run_sched_event(input sched_evt_t ev);
    sched_out_t res;
    int         n;
    int         cur;
    int         s;
    bit         found;
    n   = (int'(model_slots) > TB_TASKS) ? TB_TASKS : int'(model_slots);
    cur = (running_id >= 1 && running_id <= TB_TASKS) ? running_id - 1 : TB_TASKS;
    s   = int'(ev.sem_id) % TB_SEMS;
    res = '0;
    res.task_id = TID_W'(running_id);
    found = 1'b0;
    case (ev.action)
      ACT_SEM_INIT: sem_count[s] = ev.init_value;
      ACT_DELAY: begin
        if (cur < TB_TASKS) begin
          if (ev.delay_ticks != '0) begin
            slot_wake[cur]  = ev.now_tick + TICK_W'(ev.delay_ticks);
            slot_state[cur] = TS_DELAYED;
          end else begin
            slot_state[cur] = TS_IDLE;
          end
          running_id = 0;
        end
      end
      ACT_WAIT: begin
        if (sem_count[s] != '0) begin
          sem_count[s] = sem_count[s] - 1'b1;
          res.granted = 1'b1;
        end else if (cur < TB_TASKS) begin
          slot_state[cur] = TS_WAITING;
          slot_sem[cur]   = SEM_W'(s);
          running_id      = 0;
        end
      end
      ACT_SIGNAL: begin
        if (sem_count[s] != CNT_MAX) sem_count[s] = sem_count[s] + 1'b1;
        for (int i = 0; i < n; i++) begin
          if (slot_state[i] == TS_WAITING && slot_sem[i] == SEM_W'(s)) begin
            slot_state[i] = TS_IDLE;
            res.woken_count = res.woken_count + 1'b1;
          end
        end
      end
      ACT_DISPATCH: begin
        // a running task is yielded first
        if (cur < TB_TASKS) begin
          slot_state[cur] = TS_IDLE;
          running_id = 0;
        end
        res.task_id = '0;
        for (int i = cursor; i < n && !found; i++) begin
          if (slot_state[i] == TS_IDLE) begin
            slot_state[i]  = TS_RUNNING;
            running_id     = i + 1;
            cursor         = i + 1;
            res.task_id    = TID_W'(i + 1);
            res.dispatched = 1'b1;
            found          = 1'b1;
          end
        end
        // nothing left after the cursor: expiry scan and rewind
        if (!found) begin
          res.may_sleep = 1'b1;
          for (int i = 0; i < n; i++) begin
            if (slot_state[i] == TS_DELAYED) begin
              if (tick_passed(slot_wake[i], ev.now_tick)) begin
                slot_state[i] = TS_IDLE;
                res.woken_count = res.woken_count + 1'b1;
                res.may_sleep = 1'b0;
              end
            end else if (slot_state[i] == TS_IDLE) begin
              res.may_sleep = 1'b0;
            end
          end
          cursor = 0;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Idle length: mostly none or short, now and then long, none in calm stretches
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm_left > 0 || r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic queue_event(input logic [ACT_W-1:0]   act,
                             input logic [SEM_W-1:0]   sem,
                             input logic [CNT_W-1:0]   iv,
                             input logic [DELAY_W-1:0] dl,
                             input logic [TICK_W-1:0]  nw,
                             input logic               drain);
    sched_evt_t ev;
    ev.action      = act;
    ev.sem_id      = sem;
    ev.init_value  = iv;
    ev.delay_ticks = dl;
    ev.now_tick    = nw;
    ev.drain_first = drain;
    event_q.push_back(ev);
    events_total++;
  endtask

  // Random fields shaped so delays expire within a few scans; wild means flat random
  task automatic queue_random_event(input logic [ACT_W-1:0] act, input bit wild);
    logic [SEM_W-1:0]   sem;
    logic [CNT_W-1:0]   iv;
    logic [DELAY_W-1:0] dl;
    logic [TICK_W-1:0]  nw;
    int                 r;
    if (wild) begin
      sem = SEM_W'($urandom);
      iv  = CNT_W'($urandom);
      dl  = DELAY_W'($urandom);
      nw  = TICK_W'($urandom);
    end else begin
      sem = ($urandom_range(0, 9) < 7) ? SEM_W'($urandom_range(0, 2))
                                       : SEM_W'($urandom_range(0, 7));
      r = $urandom_range(0, 99);
      iv = (r < 40) ? '0 : (r < 70) ? CNT_W'($urandom_range(1, 3)) :
           (r < 80) ? CNT_MAX : CNT_W'($urandom);
      r = $urandom_range(0, 99);
      dl = (r < 15) ? '0 : (r < 65) ? DELAY_W'($urandom_range(1, 80)) :
           (r < 80) ? DELAY_W'($urandom_range(81, 2000)) :
           (r < 90) ? DELAY_W'($urandom) :
           (r < 95) ? '1 : DELAY_W'($urandom_range(16300, 16450));
      r = $urandom_range(0, 99);
      if (r < 85) tick_gen = tick_gen + TICK_W'($urandom_range(0, 30));
      else if (r < 93) tick_gen = tick_gen + TICK_W'($urandom_range(1000, 40000));
      nw = (r < 93) ? tick_gen : TICK_W'($urandom);
    end
    queue_event(act, sem, iv, dl, nw, act == ACT_DISPATCH && $urandom_range(0, 99) == 0);
  endtask

  // Block idle: every event taken, every result back, chain drained
  task automatic wait_idle();
    while (events_taken != events_total || outcome_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Event sender
  always @(negedge clk) begin
    if (calm_left > 0) calm_left--;
    else if ($urandom_range(0, 499) == 0) calm_left = $urandom_range(40, 150);
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_took) begin
      send_now = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (event_q.size() != 0 &&
                   !(event_q[0].drain_first && outcome_q.size() != 0)) begin
        cur_evt = event_q.pop_front();
        in_if.action      <= cur_evt.action;
        in_if.sem_id      <= cur_evt.sem_id;
        in_if.init_value  <= cur_evt.init_value;
        in_if.delay_ticks <= cur_evt.delay_ticks;
        in_if.now_tick    <= cur_evt.now_tick;
        send_now = 1'b1;
        send_gap = pick_gap();
      end
      in_if.valid <= send_now;
    end
  end

  // Result receiver with random back-pressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  // Transaction monitor: predict on accepted events, check accepted results
  always @(posedge clk) begin
    if (!rst_n) begin
      in_took = 1'b0;
    end else begin
      in_took = in_if.valid && in_if.ready;
      if (in_took) begin
        outcome_q.push_back(run_sched_event(cur_evt));
        events_taken++;
      end
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          CFG_MAX_DELAY:  model_max_delay = cfg_if.data[DELAY_W-1:0];
          CFG_TASK_COUNT: model_slots     = cfg_if.data[TCNT_W-1:0];
          default: ;
        endcase
      end
      if (out_if.valid && out_if.ready) begin
        got.task_id     = out_if.task_id;
        got.dispatched  = out_if.dispatched;
        got.granted     = out_if.granted;
        got.may_sleep   = out_if.may_sleep;
        got.woken_count = out_if.woken_count;
        if (outcome_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: unexpected result tid=%0d disp=%0b grant=%0b sleep=%0b woken=%0d",
                     $realtime, got.task_id, got.dispatched, got.granted, got.may_sleep,
                     got.woken_count);
        end else begin
          exp_res = outcome_q.pop_front();
          if (got.task_id !== exp_res.task_id || got.dispatched !== exp_res.dispatched ||
              got.granted !== exp_res.granted || got.may_sleep !== exp_res.may_sleep ||
              got.woken_count !== exp_res.woken_count) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("%0t: mismatch exp tid=%0d disp=%0b grant=%0b sleep=%0b woken=%0d %s",
                       $realtime, exp_res.task_id, exp_res.dispatched, exp_res.granted,
                       exp_res.may_sleep, exp_res.woken_count,
                       $sformatf("got tid=%0d disp=%0b grant=%0b sleep=%0b woken=%0d",
                                 got.task_id, got.dispatched, got.granted, got.may_sleep,
                                 got.woken_count));
          end
        end
      end
    end
  end

  // Stimulus: directed sequence at reset settings, then random phases
  initial begin : stimulus
    logic [ACT_W-1:0]      act;
    logic [CFG_DATA_W-1:0] md;
    logic [CFG_DATA_W-1:0] sc;
    int                    made;
    int                    r;
    rst_n = 1'b0;
    in_if.valid       = 1'b0;
    in_if.action      = '0;
    in_if.sem_id      = '0;
    in_if.init_value  = '0;
    in_if.delay_ticks = '0;
    in_if.now_tick    = '0;
    out_if.ready      = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = '0;
    cfg_if.data       = '0;
    for (int i = 0; i < TB_TASKS; i++) begin
      slot_state[i] = TS_IDLE;
      slot_wake[i]  = '0;
      slot_sem[i]   = '0;
    end
    for (int i = 0; i < TB_SEMS; i++) sem_count[i] = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // signal with no waiters, scheduler-issued delay and wait are ignored
    queue_event(ACT_SIGNAL,   3'd7, 8'd0,   15'd0,     16'd0,     1'b0);
    queue_event(ACT_SEM_INIT, 3'd0, 8'd0,   15'd0,     16'd5,     1'b0);
    queue_event(ACT_DELAY,    3'd0, 8'd255, 15'd32767, 16'hFFFF,  1'b0);
    queue_event(ACT_WAIT,     3'd0, 8'd0,   15'd0,     16'd6,     1'b0);
    queue_event(ACT_RSVD5,    3'd3, 8'd9,   15'd9,     16'd7,     1'b0);
    // two tasks park on an empty semaphore, one signal wakes both
    queue_event(ACT_DISPATCH, 3'd0, 8'd0,   15'd0,     16'd10,    1'b0);
    queue_event(ACT_WAIT,     3'd0, 8'd0,   15'd0,     16'd11,    1'b0);
    queue_event(ACT_DISPATCH, 3'd0, 8'd0,   15'd0,     16'd12,    1'b0);
    queue_event(ACT_WAIT,     3'd0, 8'd0,   15'd0,     16'd13,    1'b0);
    queue_event(ACT_SIGNAL,   3'd0, 8'd0,   15'd0,     16'd14,    1'b0);
    // granted wait, then a delay across the tick wrap and a plain yield
    queue_event(ACT_DISPATCH, 3'd0, 8'd0,   15'd0,     16'd15,    1'b0);
    queue_event(ACT_WAIT,     3'd0, 8'd0,   15'd0,     16'd16,    1'b0);
    queue_event(ACT_DELAY,    3'd0, 8'd0,   15'd100,   16'hFFF0,  1'b0);
    queue_event(ACT_DISPATCH, 3'd0, 8'd0,   15'd0,     16'hFFF1,  1'b0);
    queue_event(ACT_DELAY,    3'd0, 8'd0,   15'd0,     16'hFFF2,  1'b0);
    // counter saturates at its ceiling
    queue_event(ACT_SEM_INIT, 3'd5, 8'd255, 15'd0,     16'hFFF3,  1'b0);
    queue_event(ACT_SIGNAL,   3'd5, 8'd0,   15'd0,     16'hFFF4,  1'b0);
    queue_event(ACT_RSVD6,    3'd5, 8'd1,   15'd1,     16'hFFF5,  1'b0);
    queue_event(ACT_RSVD7,    3'd6, 8'd2,   15'd2,     16'hFFF6,  1'b0);
    // longest delay crosses the epoch bit, then dispatch past the last slot
    queue_event(ACT_DISPATCH, 3'd0, 8'd0,   15'd0,     16'd90,    1'b0);
    queue_event(ACT_DELAY,    3'd0, 8'd0,   15'd32767, 16'd100,   1'b0);
    queue_event(ACT_DISPATCH, 3'd0, 8'd0,   15'd0,     16'd101,   1'b0);
    queue_event(ACT_DISPATCH, 3'd0, 8'd0,   15'd0,     16'd102,   1'b0);
    queue_event(ACT_DISPATCH, 3'd0, 8'd0,   15'd0,     16'd103,   1'b0);
    queue_event(ACT_DISPATCH, 3'd0, 8'd0,   15'd0,     16'h0060,  1'b0);
    queue_event(ACT_DISPATCH, 3'd0, 8'd0,   15'd0,     16'h0061,  1'b0);
    wait_idle();

    for (int p = 0; p < 7; p++) begin
      md = (phase_delay[p] < 0) ? CFG_DATA_W'($urandom_range(0, 32767))
                                : CFG_DATA_W'(phase_delay[p]);
      // random slot counts also carry junk above the 4-bit field
      sc = (phase_slots[p] < 0) ? {11'($urandom), 4'($urandom_range(1, 15))}
                                : CFG_DATA_W'(phase_slots[p]);
      write_reg(CFG_MAX_DELAY, md);
      write_reg(CFG_TASK_COUNT, sc);
      tick_gen = TICK_W'($urandom);
      made = 0;
      while (made < phase_len[p]) begin
        if ($urandom_range(0, 99) < 12) begin
          queue_random_event(ACT_W'($urandom_range(0, 7)), $urandom_range(0, 1) == 1);
          made++;
        end else begin
          // dispatch followed by what the running task does
          queue_random_event(ACT_DISPATCH, 1'b0);
          made++;
          repeat ($urandom_range(0, 3)) begin
            r = $urandom_range(0, 99);
            act = (r < 30) ? ACT_WAIT : (r < 55) ? ACT_SIGNAL :
                  (r < 85) ? ACT_DELAY : ACT_SEM_INIT;
            queue_random_event(act, 1'b0);
            made++;
          end
        end
      end
      wait_idle();
    end

    if (outcome_q.size() != 0) mismatch_cnt++;
    if (mismatch_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #12_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
